// File: src/lge_pkg.sv
// Shared constants, command codes and types for the life grid engine.
// No dependencies; every other file imports this package.
package lge_pkg;

  localparam int MAX_WIDTH   = 64;
  localparam int MAX_HEIGHT  = 64;
  localparam int CFG_W       = 7;
  localparam int CFG_IDX_W   = 1;
  localparam int CMD_W       = 3;
  localparam int COORD_W     = 6;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = $clog2(MAX_HEIGHT);
  localparam int WDIM_W      = $clog2(MAX_WIDTH + 1);
  localparam int HDIM_W      = $clog2(MAX_HEIGHT + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;
  localparam logic [CFG_W-1:0]     GRID_SIZE_RESET = 7'd64;

  localparam logic [CMD_W-1:0] CMD_READ   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FILL   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_INVERT = 3'd3;
  localparam logic [CMD_W-1:0] CMD_STEP   = 3'd4;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_READ,
    OP_WRITE,
    OP_FILL,
    OP_INVERT,
    OP_STEP
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [CMD_W-1:0] cmd;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             value;
  } item_t;

  typedef struct packed {
    logic [WDIM_W-1:0] width;
    logic [HDIM_W-1:0] height;
  } dims_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// File: src/life_grid_engine.sv
// Top level of the life grid engine: front end, command queue and executor.
// Depends on lge_pkg, lge_front, lge_queue and lge_back.
//
// Commands enter on start_i with command_i, col_i, row_i and value_i; a transfer
// happens at a clock edge with start_i high and busy_o low. busy_o is high only
// while the two-entry command queue is full, so commands can be issued while
// the executor is still working. Each command yields one result: done_o is high
// for one cycle with cell_value_o (read data, else 0) and done_command_o.
// The receiver cannot stall; results appear in command order.
// Steps from the accepted command to done_o, with h the rows in use:
//   read, write cell: row read from the cell memory, then modify
//   fill, invert: one read and one write of each of the h rows
//   step generation: a three-row window slides down the grid
//   unknown command: reported from the idle state with no memory access
// Each row of a sweep is read and then written.
// The executor takes the next command from the queue only when idle.
// Sizes are written through cfg_we_i/cfg_addr_i/cfg_wdata_i while idle.
// Reset empties the queue, sets both sizes to 64 and marks every row dead
// through per-row valid bits; no clearing sweep is needed.
module life_grid_engine import lge_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [CMD_W-1:0]     command_i,
  input  logic [COORD_W-1:0]   col_i,
  input  logic [COORD_W-1:0]   row_i,
  input  logic                 value_i,
  output logic                 done_o,
  output logic                 cell_value_o,
  output logic [CMD_W-1:0]     done_command_o
);

  localparam int OUT_W = $clog2(QUEUE_DEPTH + 3);

  q_status_t        q_status;
  item_t            push_item, head_item;
  dims_t            dims;
  logic             push, pop;
  logic [OUT_W-1:0] outstanding_q, outstanding_d;

  lge_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .start_i     (start_i),
    .command_i   (command_i),
    .col_i       (col_i),
    .row_i       (row_i),
    .value_i     (value_i),
    .q_status_i  (q_status),
    .push_o      (push),
    .item_o      (push_item),
    .dims_o      (dims)
  );

  lge_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (push_item),
    .pop_i    (pop),
    .item_o   (head_item),
    .status_o (q_status)
  );

  lge_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_status_i     (q_status),
    .item_i         (head_item),
    .dims_i         (dims),
    .pop_o          (pop),
    .done_o         (done_o),
    .cell_value_o   (cell_value_o),
    .done_command_o (done_command_o)
  );

  assign busy_o = q_status.full;

  // commands transferred in but not yet reported
  always_comb begin
    outstanding_d = outstanding_q;
    if (push && !done_o) outstanding_d = outstanding_q + OUT_W'(1);
    if (done_o && !push) outstanding_d = outstanding_q - OUT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outstanding_q <= '0;
    end else begin
      outstanding_q <= outstanding_d;
    end
  end

  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> outstanding_q != '0)
    else $error("result without a pending command");

  a_outstanding_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outstanding_q <= OUT_W'(QUEUE_DEPTH + 1))
    else $error("more commands in flight than queue plus executor");

  a_cell_value_read_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && done_command_o != CMD_READ) |-> !cell_value_o)
    else $error("cell value set for a non-read command");

  a_busy_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (outstanding_q == '0) |-> !busy_o)
    else $error("busy with nothing in flight");

endmodule

// File: src/lge_front.sv
// Front end: size registers, command decode and coordinate clamping.
// Depends on lge_pkg; feeds lge_queue.
module lge_front import lge_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 start_i,
  input  logic [CMD_W-1:0]     command_i,
  input  logic [COORD_W-1:0]   col_i,
  input  logic [COORD_W-1:0]   row_i,
  input  logic                 value_i,
  input  q_status_t            q_status_i,
  output logic                 push_o,
  output item_t                item_o,
  output dims_t                dims_o
);

  logic [CFG_W-1:0] width_q, width_d;
  logic [CFG_W-1:0] height_q, height_d;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_GRID_WIDTH:  width_d  = cfg_wdata_i;
        REG_GRID_HEIGHT: height_d = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= GRID_SIZE_RESET;
      height_q <= GRID_SIZE_RESET;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  // effective sizes: 0 acts as 1, oversize acts as the built size
  always_comb begin
    int w;
    int h;
    w = int'(width_q);
    h = int'(height_q);
    if (w < 1) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    if (h < 1) h = 1;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    dims_o.width  = WDIM_W'(w);
    dims_o.height = HDIM_W'(h);
  end

  always_comb begin
    int c;
    int r;
    c = int'(col_i);
    r = int'(row_i);
    if (c > int'(dims_o.width) - 1) c = int'(dims_o.width) - 1;
    if (r > int'(dims_o.height) - 1) r = int'(dims_o.height) - 1;
    item_o.cmd   = command_i;
    item_o.col   = COL_W'(c);
    item_o.row   = ROW_W'(r);
    item_o.value = value_i;
    case (command_i)
      CMD_READ:   item_o.op = OP_READ;
      CMD_WRITE:  item_o.op = OP_WRITE;
      CMD_FILL:   item_o.op = OP_FILL;
      CMD_INVERT: item_o.op = OP_INVERT;
      CMD_STEP:   item_o.op = OP_STEP;
      default:    item_o.op = OP_NOP;
    endcase
  end

  assign push_o = start_i && !q_status_i.full;

endmodule

// File: src/lge_queue.sv
// Short command queue between the front end and the executor.
// Depends on lge_pkg.
module lge_queue import lge_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  item_t     item_i,
  input  logic      pop_i,
  output item_t     item_o,
  output q_status_t status_o
);

  item_t             slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  function automatic logic [QPTR_W-1:0] ptr_inc(logic [QPTR_W-1:0] p);
    if (p == QPTR_W'(QUEUE_DEPTH - 1)) return '0;
    return p + QPTR_W'(1);
  endfunction

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + QCNT_W'(1);
    if (pop_i && !push_i) cnt_d = cnt_q - QCNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= item_i;
  end

  assign item_o         = slot_q[rd_ptr_q];
  assign status_o.full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign status_o.empty = (cnt_q == '0);

endmodule

// File: src/lge_back.sv
// Executor: row-wide cell memory, cell access, bulk sweeps and generation step.
// Depends on lge_pkg; takes commands from lge_queue.
module lge_back import lge_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  q_status_t        q_status_i,
  input  item_t            item_i,
  input  dims_t            dims_i,
  output logic             pop_o,
  output logic             done_o,
  output logic             cell_value_o,
  output logic [CMD_W-1:0] done_command_o
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_CELL_RD = 3'd1;
  localparam logic [2:0] S_CELL_EX = 3'd2;
  localparam logic [2:0] S_BULK_RD = 3'd3;
  localparam logic [2:0] S_BULK_WR = 3'd4;
  localparam logic [2:0] S_GEN_RD  = 3'd5;
  localparam logic [2:0] S_GEN_EX  = 3'd6;

  logic [2:0]           state_q, state_d;
  item_t                item_q, item_d;
  logic [HDIM_W-1:0]    cnt_q, cnt_d, cnt_m1, h_m1;
  logic [MAX_WIDTH-1:0] prev_q, prev_d, cur_q, cur_d;
  logic                 done_q, done_d, cell_q, cell_d;
  logic [CMD_W-1:0]     cmd_q, cmd_d;

  logic [MAX_WIDTH-1:0]  mem_q [MAX_HEIGHT];
  logic [MAX_HEIGHT-1:0] row_vld_q;
  logic [MAX_WIDTH-1:0]  rd_data_q;
  logic                  rd_vld_q;
  logic                  rd_en, wr_en;
  logic [ROW_W-1:0]      rd_row, wr_row;
  logic [MAX_WIDTH-1:0]  wr_data, row_data, col_mask, nxt_row, life_row;
  logic [MAX_WIDTH-1:0]  pm, cm, nm;

  function automatic logic life_rule(logic [7:0] nb, logic alive);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) n = n + 4'(nb[i]);
    return (n == 4'd3) || (alive && n == 4'd2);
  endfunction

  // rows never written read as dead
  assign row_data = rd_vld_q ? rd_data_q : '0;
  assign cnt_m1   = cnt_q - HDIM_W'(1);
  assign h_m1     = dims_i.height - HDIM_W'(1);
  assign nxt_row  = (cnt_q < dims_i.height) ? row_data : '0;

  always_comb begin
    for (int c = 0; c < MAX_WIDTH; c++) col_mask[c] = (c < int'(dims_i.width));
  end

  assign pm = prev_q & col_mask;
  assign cm = cur_q & col_mask;
  assign nm = nxt_row & col_mask;

  always_comb begin
    logic [MAX_WIDTH-1:0] pl, pr, cl, cr, nl, nr;
    pl = {pm[MAX_WIDTH-2:0], 1'b0};
    pr = {1'b0, pm[MAX_WIDTH-1:1]};
    cl = {cm[MAX_WIDTH-2:0], 1'b0};
    cr = {1'b0, cm[MAX_WIDTH-1:1]};
    nl = {nm[MAX_WIDTH-2:0], 1'b0};
    nr = {1'b0, nm[MAX_WIDTH-1:1]};
    for (int c = 0; c < MAX_WIDTH; c++) begin
      life_row[c] = life_rule({pl[c], pm[c], pr[c], cl[c], cr[c], nl[c], nm[c], nr[c]},
                              cm[c]);
    end
  end

  always_comb begin
    state_d = state_q;
    item_d  = item_q;
    cnt_d   = cnt_q;
    prev_d  = prev_q;
    cur_d   = cur_q;
    done_d  = 1'b0;
    cell_d  = 1'b0;
    cmd_d   = cmd_q;
    pop_o   = 1'b0;
    rd_en   = 1'b0;
    rd_row  = item_q.row;
    wr_en   = 1'b0;
    wr_row  = item_q.row;
    wr_data = row_data;
    case (state_q)
      S_IDLE: begin
        if (!q_status_i.empty) begin
          pop_o  = 1'b1;
          item_d = item_i;
          cnt_d  = '0;
          prev_d = '0;
          cur_d  = '0;
          case (item_i.op)
            OP_READ, OP_WRITE: state_d = S_CELL_RD;
            OP_FILL, OP_INVERT: state_d = S_BULK_RD;
            OP_STEP: state_d = S_GEN_RD;
            default: begin
              done_d = 1'b1;
              cmd_d  = item_i.cmd;
            end
          endcase
        end
      end
      S_CELL_RD: begin
        rd_en   = 1'b1;
        state_d = S_CELL_EX;
      end
      S_CELL_EX: begin
        done_d  = 1'b1;
        cmd_d   = item_q.cmd;
        state_d = S_IDLE;
        if (item_q.op == OP_READ) begin
          cell_d = row_data[item_q.col];
        end else begin
          wr_en                = 1'b1;
          wr_data[item_q.col]  = item_q.value;
        end
      end
      S_BULK_RD: begin
        rd_en   = 1'b1;
        rd_row  = cnt_q[ROW_W-1:0];
        state_d = S_BULK_WR;
      end
      S_BULK_WR: begin
        wr_en  = 1'b1;
        wr_row = cnt_q[ROW_W-1:0];
        if (item_q.op == OP_FILL) begin
          wr_data = (row_data & ~col_mask) | (item_q.value ? col_mask : '0);
        end else begin
          wr_data = row_data ^ col_mask;
        end
        cnt_d = cnt_q + HDIM_W'(1);
        if (cnt_q == h_m1) begin
          done_d  = 1'b1;
          cmd_d   = item_q.cmd;
          state_d = S_IDLE;
        end else begin
          state_d = S_BULK_RD;
        end
      end
      S_GEN_RD: begin
        rd_en   = (cnt_q < dims_i.height);
        rd_row  = cnt_q[ROW_W-1:0];
        state_d = S_GEN_EX;
      end
      S_GEN_EX: begin
        // window: prev = row cnt-2, cur = row cnt-1, nxt = row cnt (original values)
        if (cnt_q != '0) begin
          wr_en   = 1'b1;
          wr_row  = cnt_m1[ROW_W-1:0];
          wr_data = (cur_q & ~col_mask) | (life_row & col_mask);
        end
        prev_d = cur_q;
        cur_d  = nxt_row;
        cnt_d  = cnt_q + HDIM_W'(1);
        if (cnt_q == dims_i.height) begin
          done_d  = 1'b1;
          cmd_d   = item_q.cmd;
          state_d = S_IDLE;
        end else begin
          state_d = S_GEN_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      done_q    <= 1'b0;
      row_vld_q <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (wr_en) row_vld_q[wr_row] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    cnt_q  <= cnt_d;
    prev_q <= prev_d;
    cur_q  <= cur_d;
    cell_q <= cell_d;
    cmd_q  <= cmd_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_row] <= wr_data;
    if (rd_en) begin
      rd_data_q <= mem_q[rd_row];
      rd_vld_q  <= row_vld_q[rd_row];
    end
  end

  assign done_o         = done_q;
  assign cell_value_o   = cell_q;
  assign done_command_o = cmd_q;

endmodule

// File: dv/life_grid_engine_tb.sv
// Self-checking testbench for life_grid_engine: directed and random commands
// checked against a cycle-free grid predictor. Depends on lge_pkg and the RTL.
module life_grid_engine_tb;
  import lge_pkg::*;

  localparam logic [CMD_W-1:0] CMD_RSVD5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               value;
  } cmd_item_t;

  typedef struct packed {
    logic             cell_value;
    logic [CMD_W-1:0] done_command;
  } done_rec_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr_i = REG_GRID_WIDTH;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;
  logic                 start_i = 1'b0;
  logic                 busy_o;
  logic [CMD_W-1:0]     command_i = CMD_READ;
  logic [COORD_W-1:0]   col_i = '0;
  logic [COORD_W-1:0]   row_i = '0;
  logic                 value_i = 1'b0;
  logic                 done_o;
  logic                 cell_value_o;
  logic [CMD_W-1:0]     done_command_o;

  cmd_item_t   cmd_backlog[$];
  done_rec_t   expected_done[$];
  cmd_item_t   issued_cmd;
  done_rec_t   oldest_done;
  bit          idle_bursts = 1'b1;
  int          gap_left = 0;
  int          fail_count = 0;

  // Grid predictor state
  bit              cells      [MAX_HEIGHT][MAX_WIDTH];
  bit              cells_next [MAX_HEIGHT][MAX_WIDTH];
  logic [CFG_W-1:0] width_reg  = GRID_SIZE_RESET;
  logic [CFG_W-1:0] height_reg = GRID_SIZE_RESET;

  life_grid_engine DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .command_i      (command_i),
    .col_i          (col_i),
    .row_i          (row_i),
    .value_i        (value_i),
    .done_o         (done_o),
    .cell_value_o   (cell_value_o),
    .done_command_o (done_command_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int clamp_dim(input logic [CFG_W-1:0] v, input int top);
    if (v == 0) return 1;
    if (v > top) return top;
    return int'(v);
  endfunction

  function automatic logic [CFG_W-1:0] extreme_size();
    case ($urandom_range(0, 3))
      0: return 7'd0;
      1: return 7'd1;
      2: return 7'd64;
      default: return 7'd127;
    endcase
  endfunction

  // Applies one command to the predicted grid and queues the expected result.
  task automatic life_apply(input cmd_item_t it);
    int w, h, c, r, x, y, dx, dy, n;
    logic rd;
    w = clamp_dim(width_reg, MAX_WIDTH);
    h = clamp_dim(height_reg, MAX_HEIGHT);
    c = (it.col > w - 1) ? w - 1 : int'(it.col);
    r = (it.row > h - 1) ? h - 1 : int'(it.row);
    rd = 1'b0;
    case (it.command)
      CMD_READ:  rd = cells[r][c];
      CMD_WRITE: cells[r][c] = it.value;
      CMD_FILL: begin
        for (y = 0; y < h; y++)
          for (x = 0; x < w; x++)
            cells[y][x] = it.value;
      end
      CMD_INVERT: begin
        for (y = 0; y < h; y++)
          for (x = 0; x < w; x++)
            cells[y][x] = !cells[y][x];
      end
      CMD_STEP: begin
        for (y = 0; y < h; y++) begin
          for (x = 0; x < w; x++) begin
            n = 0;
            for (dy = -1; dy <= 1; dy++)
              for (dx = -1; dx <= 1; dx++)
                if ((dx != 0 || dy != 0) && y + dy >= 0 && y + dy < h &&
                    x + dx >= 0 && x + dx < w)
                  n += cells[y + dy][x + dx];
            cells_next[y][x] = (n == 3) || (cells[y][x] && n == 2);
          end
        end
        for (y = 0; y < h; y++)
          for (x = 0; x < w; x++)
            cells[y][x] = cells_next[y][x];
      end
      default: ;
    endcase
    expected_done.push_back(done_rec_t'{rd, it.command});
  endtask

  // Driver: issues backlog commands with random idle bursts
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i  <= 1'b0;
      gap_left <= 0;
    end else begin
      if (start_i && !busy_o) begin
        life_apply(issued_cmd);
      end
      if (!(start_i && busy_o)) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          start_i  <= 1'b0;
        end else if (cmd_backlog.size() != 0) begin
          if (idle_bursts && $urandom_range(0, 5) == 0) begin
            gap_left <= $urandom_range(1, 15) - 1;
            start_i  <= 1'b0;
          end else begin
            issued_cmd = cmd_backlog.pop_front();
            start_i    <= 1'b1;
            command_i  <= issued_cmd.command;
            col_i      <= issued_cmd.col;
            row_i      <= issued_cmd.row;
            value_i    <= issued_cmd.value;
          end
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: every done transfer is checked against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_done.size() == 0) begin
        $error("unexpected result, done_command %0d", done_command_o);
        fail_count++;
      end else begin
        oldest_done = expected_done.pop_front();
        if (cell_value_o !== oldest_done.cell_value) begin
          $error("cell_value: expected %0d, actual %0d",
                 oldest_done.cell_value, cell_value_o);
          fail_count++;
        end
        if (done_command_o !== oldest_done.done_command) begin
          $error("done_command: expected %0d, actual %0d",
                 oldest_done.done_command, done_command_o);
          fail_count++;
        end
      end
    end
  end

  task automatic push_cmd(input logic [CMD_W-1:0] cmd, input int col, input int row,
                          input logic val);
    cmd_backlog.push_back(cmd_item_t'{cmd, COORD_W'(col), COORD_W'(row), val});
  endtask

  task automatic settle();
    do @(negedge clk_i);
    while (cmd_backlog.size() != 0 || start_i || expected_done.size() != 0);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_dims(input logic [CFG_W-1:0] wv, input logic [CFG_W-1:0] hv);
    settle();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= REG_GRID_WIDTH;
    cfg_wdata_i <= wv;
    @(posedge clk_i);
    cfg_addr_i  <= REG_GRID_HEIGHT;
    cfg_wdata_i <= hv;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    width_reg  = wv;
    height_reg = hv;
    @(negedge clk_i);
  endtask

  // Mostly seeds and evolves patterns inside the region; some noise commands.
  task automatic random_burst(input int n);
    int w, h, k, sel;
    w = clamp_dim(width_reg, MAX_WIDTH);
    h = clamp_dim(height_reg, MAX_HEIGHT);
    if ($urandom_range(0, 1))
      push_cmd(CMD_FILL, $urandom_range(0, 63), $urandom_range(0, 63),
               1'($urandom_range(0, 1)));
    for (k = 0; k < n; k++) begin
      sel = $urandom_range(0, 9);
      if (sel == 0)
        push_cmd(CMD_W'($urandom_range(CMD_READ, CMD_RSVD7)), $urandom_range(0, 63),
                 $urandom_range(0, 63), 1'($urandom_range(0, 1)));
      else if (sel <= 3)
        push_cmd(CMD_WRITE, $urandom_range(0, w - 1), $urandom_range(0, h - 1),
                 $urandom_range(0, 2) != 0);
      else if (sel <= 5)
        push_cmd(CMD_STEP, $urandom_range(0, 63), $urandom_range(0, 63),
                 1'($urandom_range(0, 1)));
      else if (sel <= 8) begin
        if ($urandom_range(0, 3) == 0)
          push_cmd(CMD_READ, $urandom_range(0, 63), $urandom_range(0, 63),
                   1'($urandom_range(0, 1)));
        else
          push_cmd(CMD_READ, $urandom_range(0, w - 1), $urandom_range(0, h - 1),
                   1'($urandom_range(0, 1)));
      end else
        push_cmd($urandom_range(0, 1) ? CMD_FILL : CMD_INVERT, $urandom_range(0, 63),
                 $urandom_range(0, 63), $urandom_range(0, 2) == 0);
    end
  endtask

  initial begin
    int random_items, n;
    logic [CFG_W-1:0] wv, hv;
    random_items = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed, default 64x64 grid
    push_cmd(CMD_READ, 63, 63, 1'b0);
    push_cmd(CMD_WRITE, 0, 0, 1'b1);
    push_cmd(CMD_WRITE, 63, 63, 1'b1);
    push_cmd(CMD_WRITE, 10, 10, 1'b1);
    push_cmd(CMD_WRITE, 11, 10, 1'b1);
    push_cmd(CMD_WRITE, 12, 10, 1'b1);
    push_cmd(CMD_STEP, 0, 0, 1'b0);
    push_cmd(CMD_READ, 11, 9, 1'b0);
    push_cmd(CMD_READ, 10, 10, 1'b0);
    push_cmd(CMD_READ, 0, 0, 1'b0);
    push_cmd(CMD_RSVD5, 63, 63, 1'b1);
    push_cmd(CMD_RSVD6, 0, 0, 1'b0);
    push_cmd(CMD_RSVD7, 63, 0, 1'b1);
    push_cmd(CMD_FILL, 0, 0, 1'b1);
    push_cmd(CMD_STEP, 63, 63, 1'b1);
    push_cmd(CMD_READ, 0, 0, 1'b0);
    push_cmd(CMD_INVERT, 0, 0, 1'b0);
    push_cmd(CMD_READ, 20, 30, 1'b0);

    // zero sizes act as a single cell; coordinates clamp
    set_dims(7'd0, 7'd0);
    push_cmd(CMD_WRITE, 63, 63, 1'b1);
    push_cmd(CMD_READ, 40, 2, 1'b0);
    push_cmd(CMD_STEP, 0, 0, 1'b0);
    push_cmd(CMD_READ, 0, 0, 1'b0);

    // oversize acts as full grid; live cells outside a small region count as dead
    set_dims(7'd127, 7'd127);
    push_cmd(CMD_FILL, 5, 5, 1'b1);
    set_dims(7'd3, 7'd3);
    push_cmd(CMD_INVERT, 0, 0, 1'b0);
    push_cmd(CMD_STEP, 0, 0, 1'b0);
    push_cmd(CMD_READ, 2, 1, 1'b0);

    while (random_items < 100) begin
      case ($urandom_range(0, 5))
        0: begin
          wv = extreme_size();
          hv = extreme_size();
        end
        1: begin
          wv = CFG_W'($urandom_range(0, 127));
          hv = CFG_W'($urandom_range(1, 8));
        end
        default: begin
          wv = CFG_W'($urandom_range(1, 10));
          hv = CFG_W'($urandom_range(1, 10));
        end
      endcase
      set_dims(wv, hv);
      idle_bursts = (random_items < 75) && ($urandom_range(0, 3) != 0);
      n = $urandom_range(12, 24);
      random_burst(n);
      random_items += n;
    end

    settle();
    repeat (2 * MAX_HEIGHT + 8) @(posedge clk_i);
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin
    #3_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
